[hdl/rotation_to_roll_pitch_yaw_assert.svh]
// assertion macros for the roll pitch yaw block
`ifndef ROTATION_TO_ROLL_PITCH_YAW_ASSERT_SVH
`define ROTATION_TO_ROLL_PITCH_YAW_ASSERT_SVH
`ifndef SYNTHESIS
`define RPY_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define RPY_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define RPY_ASSERT(label, clk, rst, prop)
`define RPY_ASSERT_RST(label, clk, prop)
`endif
`endif

[hdl/rpy_pkg.sv]
// shared types, constants and fixed-point helpers for the roll pitch yaw block
package rpy_pkg;
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m10;
    logic signed [15:0] m20;
    logic signed [15:0] m01;
    logic signed [15:0] m11;
    logic signed [15:0] m02;
    logic signed [15:0] m12;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               degenerate;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    in_item_t mat;
    logic     degen;
  } job_t;

  localparam int Iters = 16;
  localparam int VecW = 48;
  localparam int ZW = 20;
  localparam int NormMin = 39;
  localparam logic signed [ZW-1:0] PiU16 = 20'sd205887;
  localparam logic signed [ZW-1:0] HalfPiU16 = 20'sd102944;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [31:0] InvGain = 32'sd652032874;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [3:0] i);
    case (i)
      4'd0: atan_entry = 20'sd51472;
      4'd1: atan_entry = 20'sd30386;
      4'd2: atan_entry = 20'sd16055;
      4'd3: atan_entry = 20'sd8150;
      4'd4: atan_entry = 20'sd4091;
      4'd5: atan_entry = 20'sd2047;
      4'd6: atan_entry = 20'sd1024;
      4'd7: atan_entry = 20'sd512;
      4'd8: atan_entry = 20'sd256;
      4'd9: atan_entry = 20'sd128;
      4'd10: atan_entry = 20'sd64;
      4'd11: atan_entry = 20'sd32;
      4'd12: atan_entry = 20'sd16;
      4'd13: atan_entry = 20'sd8;
      4'd14: atan_entry = 20'sd4;
      default: atan_entry = 20'sd2;
    endcase
  endfunction
endpackage

[hdl/rpy_atan2.sv]
// pipelined atan2: normalize, quadrant fold, vectoring cordic, round and clamp
module rpy_atan2 #(
  parameter int TagW = 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [47:0]          y_in,
  input  logic signed [47:0]          x_in,
  input  logic [TagW-1:0]             tag_in,
  output logic signed [15:0]          ang,
  output logic [TagW-1:0]             tag_out
);
  localparam int W = rpy_pkg::VecW;
  localparam int ZW = rpy_pkg::ZW;
  localparam int NS = 6;
  localparam int NC = rpy_pkg::Iters;
  localparam int L = NS + 1 + NC + 1;
  localparam int KF = NS + 1 + NC;

  logic signed [W-1:0] xs [0:KF];
  logic signed [W-1:0] ys [0:KF];
  logic signed [ZW-1:0] zs [0:KF];
  logic zero_s [0:KF];
  logic [TagW-1:0] tg [0:L];
  logic signed [15:0] ang_q;

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = '0;
  assign zero_s[0] = (x_in == '0) && (y_in == '0);
  assign tg[0] = tag_in;

  // normalize: shift left 32,16,8,4,2,1 while the magnitude stays below 2^40
  for (genvar s = 0; s < NS; s++) begin : g_norm
    localparam int Sh = 32 >> s;
    logic signed [W-1:0] xn, yn;
    logic signed [W-1:0] ax, ay, mx;
    always_comb begin
      ax = xs[s][W-1] ? -xs[s] : xs[s];
      ay = ys[s][W-1] ? -ys[s] : ys[s];
      mx = (ax > ay) ? ax : ay;
      if (mx < (48'sd1 <<< (rpy_pkg::NormMin + 1 - Sh))) begin
        xn = xs[s] <<< Sh;
        yn = ys[s] <<< Sh;
      end else begin
        xn = xs[s];
        yn = ys[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        xs[s+1] <= xn;
        ys[s+1] <= yn;
        zs[s+1] <= zs[s];
        zero_s[s+1] <= zero_s[s];
        tg[s+1] <= tg[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (xs[NS][W-1]) begin
        xs[NS+1] <= -xs[NS];
        ys[NS+1] <= -ys[NS];
        zs[NS+1] <= ys[NS][W-1] ? -rpy_pkg::PiU16 : rpy_pkg::PiU16;
      end else begin
        xs[NS+1] <= xs[NS];
        ys[NS+1] <= ys[NS];
        zs[NS+1] <= '0;
      end
      zero_s[NS+1] <= zero_s[NS];
      tg[NS+1] <= tg[NS];
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    localparam int K = NS + 1 + i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[K][W-1]) begin
          xs[K+1] <= xs[K] + (ys[K] >>> i);
          ys[K+1] <= ys[K] - (xs[K] >>> i);
          zs[K+1] <= zs[K] + rpy_pkg::atan_entry(4'(i));
        end else begin
          xs[K+1] <= xs[K] - (ys[K] >>> i);
          ys[K+1] <= ys[K] + (xs[K] >>> i);
          zs[K+1] <= zs[K] - rpy_pkg::atan_entry(4'(i));
        end
        zero_s[K+1] <= zero_s[K];
        tg[K+1] <= tg[K];
      end
    end
  end

  always_comb begin
    logic signed [ZW-1:0] r;
    r = (zs[KF] + ZW'(4)) >>> 3;
    if (zero_s[KF]) ang_q = '0;
    else if (r > ZW'(rpy_pkg::PiQ13)) ang_q = rpy_pkg::PiQ13;
    else if (r < -ZW'(rpy_pkg::PiQ13)) ang_q = -rpy_pkg::PiQ13;
    else ang_q = r[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tg[L] <= tg[KF];
      ang <= ang_q;
    end
  end
  assign tag_out = tg[L];
endmodule

[hdl/rpy_sincos.sv]
// pipelined rotation cordic giving q2.14 sine and cosine of a q3.13 angle
module rpy_sincos #(
  parameter int TagW = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [15:0]   ang,
  input  logic [TagW-1:0]      tag_in,
  output logic signed [15:0]   s,
  output logic signed [15:0]   c,
  output logic [TagW-1:0]      tag_out
);
  localparam int W = 34;
  localparam int ZW = rpy_pkg::ZW;
  localparam int NC = rpy_pkg::Iters;

  logic signed [W-1:0] xs [0:NC];
  logic signed [W-1:0] ys [0:NC];
  logic signed [ZW-1:0] zs [0:NC];
  logic ng [0:NC];
  logic [TagW-1:0] tg [0:NC+1];

  always_ff @(posedge clk) begin
    logic signed [ZW-1:0] z;
    z = ZW'(ang) <<< 3;
    if (en) begin
      xs[0] <= W'(rpy_pkg::InvGain);
      ys[0] <= '0;
      tg[0] <= tag_in;
      if (z > rpy_pkg::HalfPiU16) begin
        zs[0] <= z - rpy_pkg::PiU16;
        ng[0] <= 1'b1;
      end else if (z < -rpy_pkg::HalfPiU16) begin
        zs[0] <= z + rpy_pkg::PiU16;
        ng[0] <= 1'b1;
      end else begin
        zs[0] <= z;
        ng[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][ZW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - rpy_pkg::atan_entry(4'(i));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + rpy_pkg::atan_entry(4'(i));
        end
        ng[i+1] <= ng[i];
        tg[i+1] <= tg[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [W-1:0] xf, yf, xr, yr;
    xf = ng[NC] ? -xs[NC] : xs[NC];
    yf = ng[NC] ? -ys[NC] : ys[NC];
    xr = (xf + W'(32768)) >>> 16;
    yr = (yf + W'(32768)) >>> 16;
    if (en) begin
      tg[NC+1] <= tg[NC];
      c <= xr[15:0];
      s <= yr[15:0];
    end
  end
  assign tag_out = tg[NC+1];
endmodule

[hdl/rpy_front.sv]
// front end: degeneracy test, job queue
module rpy_front #(
  parameter int Depth = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  rpy_pkg::in_item_t in_item,
  input  logic [9:0]        limit,
  output logic              job_valid,
  output rpy_pkg::job_t     job,
  input  logic              job_take
);
  localparam int AW = $clog2(Depth);
  rpy_pkg::job_t mem [0:Depth-1];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;
  logic do_push, do_pop;
  logic [15:0] a00, a10;
  logic degen;

  always_comb begin
    a00 = in_item.m00[15] ? 16'(-in_item.m00) : in_item.m00;
    a10 = in_item.m10[15] ? 16'(-in_item.m10) : in_item.m10;
    degen = (a00 <= {6'd0, limit}) && (a10 <= {6'd0, limit});
  end

  assign full = (count == (AW+1)'(Depth));
  assign do_push = push && !full;
  assign job_valid = (count != '0);
  assign do_pop = job_take && job_valid;
  assign job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= '{mat: in_item, degen: degen};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  `include "rotation_to_roll_pitch_yaw_assert.svh"
  `RPY_ASSERT(a_no_overflow, clk, rst, full |-> !do_push)
  `RPY_ASSERT(a_count_step, clk, rst, (do_push && !do_pop) |=> count == $past(count) + 1'b1)
  `RPY_ASSERT_RST(a_reset_empty, clk, rst |=> !job_valid)
endmodule

[hdl/rpy_back.sv]
// back end: pipelined roll, sin/cos, products, pitch and yaw, output queue
module rpy_back #(
  parameter int OutDepth = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  rpy_pkg::job_t      job,
  output logic               job_take,
  output logic               empty,
  input  logic               pop,
  output rpy_pkg::out_item_t out_item
);
  localparam int LatA = 24;   // atan2 latency
  localparam int LatS = 18;   // sincos latency
  localparam int Lat = LatA + LatS + 2 + LatA;
  localparam int AW = $clog2(OutDepth);
  localparam int TW = 1 + 7 * 16;

  // pipeline runs continuously; credit counter keeps room in the output queue
  logic [AW:0] mcount, inflight;
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic out_valid;
  logic en_pipe;
  assign en_pipe = 1'b1;
  assign job_take = job_valid &&
                    ((mcount + (AW+1)'(out_valid) + inflight) < (AW+1)'(OutDepth));

  logic [Lat-1:0] vpipe;
  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else vpipe <= {vpipe[Lat-2:0], job_take};
  end

  // roll stage
  logic signed [15:0] roll_a;
  logic [TW-1:0] t1;
  rpy_atan2 #(.TagW(TW)) u_roll (
    .clk(clk), .en(en_pipe),
    .y_in(48'(job.mat.m10)), .x_in(48'(job.mat.m00)),
    .tag_in({job.degen, job.mat}), .ang(roll_a), .tag_out(t1)
  );

  logic signed [15:0] roll_r;
  assign roll_r = t1[TW-1] ? 16'sd0 : roll_a;

  logic signed [15:0] sp, cp;
  logic [TW+15:0] t2;
  rpy_sincos #(.TagW(TW+16)) u_sc (
    .clk(clk), .en(en_pipe), .ang(roll_r),
    .tag_in({roll_r, t1}), .s(sp), .c(cp), .tag_out(t2)
  );

  rpy_pkg::in_item_t m2;
  assign m2 = t2[TW-2:0];

  // products, one multiplier level then sums
  logic signed [31:0] p0, p1, p2, p3, p4, p5;
  logic [TW+15:0] t3;
  always_ff @(posedge clk) begin
    p0 <= cp * m2.m00; p1 <= sp * m2.m10;
    p2 <= sp * m2.m02; p3 <= cp * m2.m12;
    p4 <= cp * m2.m11; p5 <= sp * m2.m01;
    t3 <= t2;
  end

  rpy_pkg::in_item_t m3;
  assign m3 = t3[TW-2:0];

  // degenerate matrices take the raw elements as atan2 operands
  logic signed [47:0] py, px, yy, yx;
  logic [TW+15:0] t4;
  always_ff @(posedge clk) begin
    t4 <= t3;
    if (t3[TW-1]) begin
      py <= -48'(m3.m20); px <= 48'(m3.m00);
      yy <= -48'(m3.m12); yx <= 48'(m3.m11);
    end else begin
      py <= -(48'(m3.m20) <<< 14); px <= 48'(p0) + 48'(p1);
      yy <= 48'(p2) - 48'(p3); yx <= 48'(p4) - 48'(p5);
    end
  end

  logic signed [15:0] pitch_a, yaw_a;
  logic [TW+15:0] t5, t6;
  rpy_atan2 #(.TagW(TW+16)) u_pitch (
    .clk(clk), .en(en_pipe), .y_in(py), .x_in(px),
    .tag_in(t4), .ang(pitch_a), .tag_out(t5)
  );
  rpy_atan2 #(.TagW(TW+16)) u_yaw (
    .clk(clk), .en(en_pipe), .y_in(yy), .x_in(yx),
    .tag_in(t4), .ang(yaw_a), .tag_out(t6)
  );

  rpy_pkg::out_item_t res;
  assign res = '{roll_angle: signed'(t5[TW+15:TW]), pitch_angle: pitch_a,
                 yaw_angle: yaw_a, degenerate: t5[TW-1]};

  logic res_valid;
  assign res_valid = vpipe[Lat-1];

  // result memory with a registered head entry on the output ports
  rpy_pkg::out_item_t mem [0:OutDepth-1];
  logic do_pop, load;
  assign empty = !out_valid;
  assign do_pop = pop && out_valid;
  assign load = (mcount != '0) && (!out_valid || do_pop);
  always_ff @(posedge clk) begin
    if (res_valid) mem[wr_ptr] <= res;
    if (load) out_item <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; mcount <= '0; inflight <= '0; out_valid <= 1'b0;
    end else begin
      if (res_valid) wr_ptr <= wr_ptr + 1'b1;
      if (load) rd_ptr <= rd_ptr + 1'b1;
      mcount <= mcount + (AW+1)'(res_valid) - (AW+1)'(load);
      if (load) out_valid <= 1'b1;
      else if (do_pop) out_valid <= 1'b0;
      inflight <= inflight + (AW+1)'(job_take) - (AW+1)'(res_valid);
    end
  end

  `include "rotation_to_roll_pitch_yaw_assert.svh"
  `RPY_ASSERT(a_room, clk, rst, (mcount + (AW+1)'(out_valid) + inflight) <= (AW+1)'(OutDepth))
  `RPY_ASSERT(a_land, clk, rst, res_valid |-> (inflight != '0))
  `RPY_ASSERT(a_deg_roll, clk, rst, (res_valid && res.degenerate) |-> res.roll_angle == 16'sd0)
  `RPY_ASSERT(a_tags_aligned, clk, rst, res_valid |-> (t6 == t5))
endmodule

[hdl/rotation_to_roll_pitch_yaw.sv]
// top level of the rotation matrix to roll pitch yaw converter
// channel | direction | handshake        | payload
// in      | input     | push / full      | in_item (seven q2.14 elements)
// out     | output     | pop / empty      | out_item (three q3.13 angles, flag)
// cfg     | input     | cfg_valid / ready | cfg_data (10-bit near-zero limit)
// one matrix per cycle while the output queue has room; path from input to ports:
// input queue, roll atan2, sin/cos, products, pitch/yaw atan2, output queue
// a credit count against the output queue stalls the input when it would overfill
// synchronous reset empties both queues and clears the limit to zero
module rotation_to_roll_pitch_yaw #(
  parameter int InDepth = 4,
  parameter int OutDepth = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  rpy_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output rpy_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [9:0]         cfg_data
);
  logic [9:0] limit;
  logic job_valid, job_take;
  rpy_pkg::job_t job;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) limit <= '0;
    else if (cfg_valid) limit <= cfg_data;
  end

  rpy_front #(.Depth(InDepth)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .limit(limit), .job_valid(job_valid), .job(job), .job_take(job_take)
  );

  rpy_back #(.OutDepth(OutDepth)) u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job), .job_take(job_take),
    .empty(empty), .pop(pop), .out_item(out_item)
  );
endmodule
